// ----- rtl/core/ts_packet_sync_search_defines.svh -----
// Assertion macros for the transport-stream sync search.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TS_PACKET_SYNC_SEARCH_DEFINES_SVH
`define TS_PACKET_SYNC_SEARCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ts_packet_sync_search: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ts_packet_sync_search: next-cycle check failed");

`endif

// ----- rtl/core/tsps_pkg.sv -----
// Shared types and constants for the transport-stream sync search.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsps_pkg;

  localparam int unsigned PacketBytesDef = 192;
  localparam int unsigned RunNeededDef   = 8;

  // phase index covers every packet length from 188 to 256
  localparam int unsigned PhaseW     = 8;
  localparam int unsigned CntW       = 4;
  localparam int unsigned PosW       = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0]      SyncByte = 8'h47;
  localparam logic [PosW-1:0] PosMax   = '1;
  localparam logic [CntW-1:0] CntMax   = '1;

  localparam logic StatusFound  = 1'b0;
  localparam logic StatusNoSync = 1'b1;

  typedef struct packed {
    logic              judge;
    logic              good;
    logic              first_lap;
    logic [PhaseW-1:0] phase;
    logic [PosW-1:0]   offset;
    logic              start;
    logic              last;
  } tsps_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsps_q_status_t;

  typedef struct packed {
    logic res_fire;
    logic finished;
  } tsps_back_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/tsps_front.sv -----
// Front end: tracks byte position, recent bytes and header phase, and
// classifies each request into a queue entry. Depends on tsps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsps_front #(
  parameter int unsigned PACKET_BYTES = tsps_pkg::PacketBytesDef,
  parameter int unsigned RUN_NEEDED   = tsps_pkg::RunNeededDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           stream_byte_i,
  input  logic                 search_start_i,
  input  logic                 end_of_data_i,
  output tsps_pkg::tsps_entry_t entry_o
);
  import tsps_pkg::*;

  localparam logic [PosW-1:0]   RunBack   = PosW'((RUN_NEEDED - 1) * PACKET_BYTES + 3);
  localparam logic [PosW-1:0]   FirstHdr  = PosW'(3);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(PACKET_BYTES - 1);

  logic [PosW-1:0]   pos_q, pos_d, pos_eff;
  logic [23:0]       rec_q, rec_d, rec_eff;
  logic [PhaseW-1:0] phase_q, phase_d, phase_eff;
  logic              lap_q, lap_d, lap_eff;
  logic              judge, good;

  always_comb begin
    pos_eff   = search_start_i ? '0 : pos_q;
    rec_eff   = search_start_i ? '0 : rec_q;
    phase_eff = search_start_i ? '0 : phase_q;
    lap_eff   = search_start_i ? 1'b1 : lap_q;

    judge = (pos_eff >= FirstHdr) && (pos_eff != PosMax);
    good  = (rec_eff[23:16] == SyncByte) && (stream_byte_i[7:6] == 2'b00) &&
            (stream_byte_i[5:4] != 2'b00);

    pos_d   = pos_eff;
    rec_d   = rec_eff;
    phase_d = phase_eff;
    lap_d   = lap_eff;
    if (pos_eff != PosMax) begin
      pos_d = pos_eff + PosW'(1);
      rec_d = {rec_eff[15:0], stream_byte_i};
    end
    if (judge) begin
      phase_d = (phase_eff == PhaseLast) ? '0 : phase_eff + PhaseW'(1);
      lap_d   = lap_eff && (phase_eff != PhaseLast);
    end

    entry_o.judge     = judge;
    entry_o.good      = good;
    entry_o.first_lap = lap_eff;
    entry_o.phase     = phase_eff;
    entry_o.offset    = (pos_eff >= RunBack) ? pos_eff - RunBack : '0;
    entry_o.start     = search_start_i;
    entry_o.last      = end_of_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      rec_q   <= '0;
      phase_q <= '0;
      lap_q   <= 1'b1;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      rec_q   <= rec_d;
      phase_q <= phase_d;
      lap_q   <= lap_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tsps_queue.sv -----
// Two-entry queue between front and back end.
// Depends on tsps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsps_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  tsps_pkg::tsps_entry_t    data_i,
  input  logic                     pop_i,
  output tsps_pkg::tsps_entry_t    data_o,
  output tsps_pkg::tsps_q_status_t status_o
);
  import tsps_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tsps_entry_t       mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tsps_back.sv -----
// Back end: per-phase run count memory, read stage, update and result register.
// Depends on tsps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsps_back #(
  parameter int unsigned PACKET_BYTES = tsps_pkg::PacketBytesDef,
  parameter int unsigned RUN_NEEDED   = tsps_pkg::RunNeededDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsps_pkg::tsps_entry_t       head_i,
  input  logic                        head_valid_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [tsps_pkg::PosW-1:0]   sync_offset_o,
  output tsps_pkg::tsps_back_status_t status_info_o
);
  import tsps_pkg::*;

  localparam logic [CntW-1:0] RunNeed = CntW'(RUN_NEEDED);

  logic [CntW-1:0] cnt_mem [PACKET_BYTES];

  tsps_entry_t     s1_q;
  logic            s1_v_q;
  logic [CntW-1:0] rd_q;
  logic            fin_q, fin_eff;
  logic            out_v_q, out_status_q;
  logic [PosW-1:0] out_off_q;

  logic            out_free, s1_fire, load, we, found, res_v;
  logic [CntW-1:0] cnt;

  always_comb begin
    out_free = !out_v_q || !out_stall_i;
    s1_fire  = s1_v_q && out_free;
    load     = head_valid_i && (!s1_v_q || s1_fire);
    fin_eff  = s1_q.start ? 1'b0 : fin_q;

    priority if (!s1_q.good) begin
      cnt = '0;
    end else if (s1_q.first_lap) begin
      cnt = CntW'(1);
    end else begin
      cnt = (rd_q == CntMax) ? CntMax : rd_q + CntW'(1);
    end

    we    = s1_fire && !fin_eff && s1_q.judge;
    found = s1_q.judge && (cnt >= RunNeed);
    res_v = !fin_eff && (found || s1_q.last);
  end

  assign pop_o = load;

  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[s1_q.phase] <= cnt;
    end
    if (load) begin
      rd_q <= cnt_mem[head_i.phase];
      s1_q <= head_i;
    end
    if (s1_fire && res_v) begin
      out_status_q <= found ? StatusFound : StatusNoSync;
      out_off_q    <= found ? s1_q.offset : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fin_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        fin_q <= fin_eff || res_v;
      end
      if (s1_fire && res_v) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o            = out_v_q;
  assign status_o               = out_status_q;
  assign sync_offset_o          = out_off_q;
  assign status_info_o.res_fire = s1_fire && res_v;
  assign status_info_o.finished = fin_q;

endmodule
`default_nettype wire

// ----- rtl/core/ts_packet_sync_search.sv -----
// Top level of the transport-stream packet sync search.
// Instantiates tsps_front, tsps_queue and tsps_back; uses tsps_pkg and the defines header.
//
// Takes one stream byte per cycle, sustained, with no gaps of its own: the
// per-phase run count memory is read once and written once per byte, at
// different phases, so no byte waits on the one before it. A result is offered
// once the byte that causes it has passed the queue, the read stage and the
// result register. While the receiver stalls a waiting result, the back
// end holds, and the input stalls once the two-entry queue is full. The count
// memory needs no clearing pass after reset, as the first header of each phase
// writes its entry without using the old value that it reads.
`timescale 1ns / 1ps
`default_nettype none
`include "ts_packet_sync_search_defines.svh"
module ts_packet_sync_search #(
  parameter int unsigned PACKET_BYTES = tsps_pkg::PacketBytesDef,
  parameter int unsigned RUN_NEEDED   = tsps_pkg::RunNeededDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                stream_byte_i,
  input  logic                      search_start_i,
  input  logic                      end_of_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      status_o,
  output logic [tsps_pkg::PosW-1:0] sync_offset_o
);
  import tsps_pkg::*;

  tsps_entry_t       fe_entry, q_head;
  tsps_q_status_t    q_st;
  tsps_back_status_t bk_st;
  logic              accept, pop;

  assign in_stall_o = q_st.full;
  assign accept     = in_valid_i && !q_st.full;

  tsps_front #(
    .PACKET_BYTES(PACKET_BYTES),
    .RUN_NEEDED  (RUN_NEEDED)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .stream_byte_i  (stream_byte_i),
    .search_start_i (search_start_i),
    .end_of_data_i  (end_of_data_i),
    .entry_o        (fe_entry)
  );

  tsps_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .data_i   (fe_entry),
    .pop_i    (pop),
    .data_o   (q_head),
    .status_o (q_st)
  );

  tsps_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .RUN_NEEDED  (RUN_NEEDED)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .head_valid_i  (!q_st.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .sync_offset_o (sync_offset_o),
    .status_info_o (bk_st)
  );

  `TSPS_ASSERT_NOW(a_nosync_zero, out_valid_o && status_o == StatusNoSync, sync_offset_o == '0)
  `TSPS_ASSERT_NEXT(a_fin_after_result, bk_st.res_fire, bk_st.finished && out_valid_o)
  `TSPS_ASSERT_NOW(a_queue_bound, q_st.full, !q_st.empty)

endmodule
`default_nettype wire
